@@ rtl/core/tbp_pkg.sv @@
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types and constants for the tilt balance controller: transaction
// payloads, control groups and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package tbp_pkg;

    // Shared multiplier operand and product widths
    localparam int MAC_A_W = 33;
    localparam int MAC_B_W = 18;
    localparam int MAC_P_W = MAC_A_W + MAC_B_W;

    // Reciprocal of 131 scaled by 2**24, exact for magnitudes below 2**17
    localparam logic signed [MAC_B_W-1:0] RECIP_131 = 18'sd128071;
    localparam int RECIP_SHIFT = 24;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OGAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GBIAS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ABIAS  = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_KP     = 16'd256;
    localparam logic [15:0] RST_KI     = 16'd256;
    localparam logic [15:0] RST_KD     = 16'd256;
    localparam logic [15:0] RST_ALPHA  = 16'd64225;
    localparam logic [15:0] RST_OGAIN  = 16'd1000;
    localparam logic [15:0] RST_PERIOD = 16'd1000;
    localparam logic [15:0] RST_GBIAS  = 16'hFF2B;  // -213
    localparam logic [15:0] RST_ABIAS  = 16'hFD1E;  // -738
    localparam logic [15:0] RST_DUTY   = 16'd50;

    // Accumulator shift selection
    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_16   = 2'd1;
    localparam logic [1:0] SH_FRAC = 2'd2;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] accel_x;
        logic signed [15:0] gyro_x;
    } t_in_item;

    typedef struct packed {
        logic               pin_forward;
        logic               pin_reverse;
        logic signed [15:0] tilt_angle;
        logic [15:0]        duty_count;
        logic               dir_forward;
        logic signed [31:0] drive_value;
    } t_out_item;

    typedef struct packed {
        logic       mul_en;
        logic       acc_en;
        logic       acc_clr;
        logic [1:0] shift_sel;
    } t_mac_ctl;

    typedef struct packed {
        logic        tick;
        logic        fwd_flag;
        logic [15:0] duty;
        logic [15:0] period;
    } t_pwm_ctl;

endpackage

@@ rtl/core/tbp_in_if.sv @@
// ----------------------------------------------------------------------------
// tbp_in_if
// Input channel: sensor sample or PWM tick transactions.
// ----------------------------------------------------------------------------
interface tbp_in_if;
    import tbp_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/tbp_out_if.sv @@
// ----------------------------------------------------------------------------
// tbp_out_if
// Output channel: one result transaction per accepted input.
// ----------------------------------------------------------------------------
interface tbp_out_if;
    import tbp_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/tbp_mac.sv @@
// ----------------------------------------------------------------------------
// tbp_mac
// Shared signed multiplier with a registered product and a shifting
// accumulator, stepped by the controller sequencer.
// ----------------------------------------------------------------------------
module tbp_mac #(
    parameter int ACC_W = 52,
    parameter int FRAC  = 16
) (
    input  logic                                  i_clk,
    input  tbp_pkg::t_mac_ctl                     i_ctl,
    input  logic signed [tbp_pkg::MAC_A_W-1:0]    i_op_a,
    input  logic signed [tbp_pkg::MAC_B_W-1:0]    i_op_b,
    output logic signed [tbp_pkg::MAC_P_W-1:0]    o_prod,
    output logic signed [ACC_W-1:0]               o_acc
);
    import tbp_pkg::*;

    logic signed [MAC_P_W-1:0] r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   s_ext;
    logic signed [ACC_W-1:0]   s_addend;
    logic signed [ACC_W-1:0]   s_base;

    // Align the registered product for the accumulator
    always_comb begin
        s_ext = ACC_W'(r_prod);
        case (i_ctl.shift_sel)
            SH_NONE: s_addend = s_ext;
            SH_16:   s_addend = s_ext <<< 16;
            SH_FRAC: s_addend = s_ext <<< FRAC;
            default: s_addend = s_ext;
        endcase
        s_base = i_ctl.acc_clr ? '0 : r_acc;
    end

    // Multiply into the product register, then accumulate the registered product
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
        if (i_ctl.acc_en) begin
            r_acc <= s_base + s_addend;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

@@ rtl/core/tbp_pwm.sv @@
// ----------------------------------------------------------------------------
// tbp_pwm
// PWM tick counter and motor drive pins: clear on duty match, raise the
// selected pin at the end of each period unless the duty is zero.
// ----------------------------------------------------------------------------
module tbp_pwm #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tbp_pkg::t_pwm_ctl i_ctl,
    output logic              o_pin_fwd,
    output logic              o_pin_rev
);
    import tbp_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic [COUNT_WIDTH-1:0] s_inc;
    logic                   r_fwd;
    logic                   r_rev;
    logic                   n_fwd;
    logic                   n_rev;
    logic                   s_match;
    logic                   s_wrap;

    // Advance the counter and work out the pin levels for this tick
    always_comb begin
        s_inc   = r_cnt + 1'b1;
        s_match = CMP_W'(s_inc) == CMP_W'(i_ctl.duty);
        s_wrap  = CMP_W'(s_inc) >= CMP_W'(i_ctl.period);
        n_cnt   = r_cnt;
        n_fwd   = r_fwd;
        n_rev   = r_rev;
        if (i_ctl.tick) begin
            n_cnt = s_inc;
            if (s_match) begin
                n_fwd = 1'b0;
                n_rev = 1'b0;
            end
            if (s_wrap) begin
                n_cnt = '0;
                if (i_ctl.duty != '0) begin
                    if (i_ctl.fwd_flag) begin
                        n_fwd = 1'b1;
                    end else begin
                        n_rev = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_fwd <= 1'b0;
            r_rev <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_fwd <= n_fwd;
            r_rev <= n_rev;
        end
    end

    assign o_pin_fwd = r_fwd;
    assign o_pin_rev = r_rev;

endmodule

@@ rtl/core/tilt_balance_pid_pwm_top.sv @@
// ----------------------------------------------------------------------------
// tilt_balance_pid_pwm_top
// Complementary tilt filter, PID loop and PWM motor drive on one shared
// multiplier.
// ----------------------------------------------------------------------------
// Each input transaction is a sensor sample or a PWM tick, and each gives one
// result transaction. A tick updates the PWM counter and pins in the accept
// cycle and offers its result on the next cycle. A sample runs 15 steps on
// the single 33x18 multiply-accumulate unit (gyro scaling, three filter
// products, three PID products, the duty product and their saturations) and
// offers its result once the duty step is done. The input is not ready from
// acceptance until the result has been taken. Configuration writes take
// effect at once and belong between transactions.
// ----------------------------------------------------------------------------
module tilt_balance_pid_pwm_top #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int COUNT_WIDTH     = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tbp_in_if.sink                            i_in,
    tbp_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [tbp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [15:0]                       i_cfg_data
);
    import tbp_pkg::*;

    localparam int F     = ANGLE_FRAC_BITS;
    localparam int EST_W = 18 + F;
    localparam int A_W   = 19 + F;
    localparam int ACC_W = (F + 36 > 52) ? F + 36 : 52;

    localparam logic signed [ACC_W-1:0] EST_HI = ACC_W'((64'sd1 <<< (EST_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] EST_LO = -EST_HI - ACC_W'(64'sd1);
    localparam logic signed [ACC_W-1:0] D_HI   = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] D_LO   = -D_HI - ACC_W'(64'sd1);
    localparam logic signed [32:0]      I_HI   = 33'sh0_7FFF_FFFF;
    localparam logic signed [32:0]      I_LO   = -I_HI - 33'sd1;

    // Sequencer codes
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_GMUL = 5'd1;
    localparam logic [4:0] S_GFIN = 5'd2;
    localparam logic [4:0] S_M0   = 5'd3;
    localparam logic [4:0] S_M1   = 5'd4;
    localparam logic [4:0] S_M2   = 5'd5;
    localparam logic [4:0] S_M3   = 5'd6;
    localparam logic [4:0] S_EST  = 5'd7;
    localparam logic [4:0] S_INT  = 5'd8;
    localparam logic [4:0] S_PMUL = 5'd9;
    localparam logic [4:0] S_IMUL = 5'd10;
    localparam logic [4:0] S_DMUL = 5'd11;
    localparam logic [4:0] S_DSUM = 5'd12;
    localparam logic [4:0] S_DRV  = 5'd13;
    localparam logic [4:0] S_OMUL = 5'd14;
    localparam logic [4:0] S_DUTY = 5'd15;
    localparam logic [4:0] S_OUT  = 5'd16;

    // Configuration registers
    logic signed [15:0] r_kp, r_ki, r_kd, r_gbias, r_abias;
    logic [15:0]        r_alpha, r_ogain, r_period;

    // Controller state
    logic [4:0]              r_state, n_state;
    logic signed [EST_W-1:0] r_est;
    logic signed [31:0]      r_int;
    logic signed [16:0]      r_last;
    logic [15:0]             r_duty;
    logic                    r_fwd;
    logic signed [15:0]      r_angle;
    logic signed [31:0]      r_drive;

    // Work registers
    logic signed [16:0]      r_gd, r_ad;
    logic signed [A_W-1:0]   r_a;
    logic signed [2:0]       r_accel;
    logic signed [16:0]      r_err;
    logic signed [17:0]      r_deriv;

    // Shared unit connections
    t_mac_ctl                    s_ctl;
    logic signed [MAC_A_W-1:0]   s_op_a;
    logic signed [MAC_B_W-1:0]   s_op_b;
    logic signed [MAC_P_W-1:0]   s_prod;
    logic signed [ACC_W-1:0]     s_acc;
    t_pwm_ctl                    s_pwm;
    logic                        s_pin_fwd, s_pin_rev;

    // Datapath helpers
    logic                    s_accept;
    logic [15:0]             s_gmag, s_amag;
    logic [8:0]              s_gq;
    logic signed [9:0]       s_gyro;
    logic signed [2:0]       s_accel;
    logic signed [A_W-1:0]   s_a;
    logic signed [ACC_W-1:0] s_est_sh;
    logic signed [ACC_W-1:0] s_est_sat;
    logic signed [17:0]      s_aq, s_aadj;
    logic                    s_ainc;
    logic signed [15:0]      s_angle;
    logic signed [16:0]      s_err;
    logic signed [32:0]      s_isum;
    logic signed [31:0]      s_isat;
    logic signed [31:0]      s_dsat;
    logic signed [32:0]      s_dmag;
    logic [42:0]             s_p8;
    logic [15:0]             s_duty;

    assign s_accept = i_in.valid && i_in.ready;

    // Gyro and accel scaling, filter input and saturations
    always_comb begin
        s_gmag  = r_gd[16] ? 16'(-r_gd) : 16'(r_gd);
        s_gq    = s_prod[RECIP_SHIFT+8:RECIP_SHIFT];
        s_gyro  = r_gd[16] ? -$signed({1'b0, s_gq}) : $signed({1'b0, s_gq});
        s_amag  = r_ad[16] ? 16'(-r_ad) : 16'(r_ad);
        s_accel = r_ad[16] ? -$signed({1'b0, s_amag[15:14]}) : $signed({1'b0, s_amag[15:14]});
        s_a     = A_W'(r_est) + (A_W'(s_gyro) <<< F);

        // Floor by 2**16, then clamp the estimate
        s_est_sh = s_acc >>> 16;
        if (s_est_sh > EST_HI) begin
            s_est_sat = EST_HI;
        end else if (s_est_sh < EST_LO) begin
            s_est_sat = EST_LO;
        end else begin
            s_est_sat = s_est_sh;
        end

        // Integer angle, truncated toward zero
        s_aq   = 18'(r_est >>> F);
        s_ainc = r_est[EST_W-1] && (r_est[F-1:0] != '0);
        s_aadj = s_aq + $signed({17'b0, s_ainc});
        if (s_aadj > 18'sd32767) begin
            s_angle = 16'sh7FFF;
        end else if (s_aadj < -18'sd32768) begin
            s_angle = -16'sh8000;
        end else begin
            s_angle = 16'(s_aadj);
        end
        s_err = -17'(s_angle);

        // Saturating integral
        s_isum = 33'(r_int) + 33'(s_err);
        if (s_isum > I_HI) begin
            s_isat = 32'(I_HI);
        end else if (s_isum < I_LO) begin
            s_isat = 32'(I_LO);
        end else begin
            s_isat = 32'(s_isum);
        end

        // Saturating drive
        if (s_acc > D_HI) begin
            s_dsat = 32'(D_HI);
        end else if (s_acc < D_LO) begin
            s_dsat = 32'(D_LO);
        end else begin
            s_dsat = 32'(s_acc);
        end

        // Duty magnitude and clamp to the period
        s_dmag = r_drive[31] ? -33'(r_drive) : 33'(r_drive);
        s_p8   = s_prod[MAC_P_W-1:8];
        s_duty = (s_p8 > {27'b0, r_period}) ? r_period : s_p8[15:0];
    end

    // Sequencer and shared unit operand selection
    always_comb begin
        n_state = r_state;
        s_ctl   = '0;
        s_op_a  = '0;
        s_op_b  = '0;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = i_in.data.req_type ? S_OUT : S_GMUL;
                end
            end
            S_GMUL: begin
                s_ctl.mul_en = 1'b1;
                s_op_a  = MAC_A_W'({1'b0, s_gmag});
                s_op_b  = RECIP_131;
                n_state = S_GFIN;
            end
            S_GFIN: n_state = S_M0;
            S_M0: begin
                s_ctl.mul_en = 1'b1;
                s_op_a  = MAC_A_W'({1'b0, r_a[15:0]});
                s_op_b  = MAC_B_W'({1'b0, r_alpha});
                n_state = S_M1;
            end
            S_M1: begin
                s_ctl   = '{mul_en: 1'b1, acc_en: 1'b1, acc_clr: 1'b1, shift_sel: SH_NONE};
                s_op_a  = MAC_A_W'($signed(r_a[A_W-1:16]));
                s_op_b  = MAC_B_W'({1'b0, r_alpha});
                n_state = S_M2;
            end
            S_M2: begin
                s_ctl   = '{mul_en: 1'b1, acc_en: 1'b1, acc_clr: 1'b0, shift_sel: SH_16};
                s_op_a  = MAC_A_W'(r_accel);
                s_op_b  = 18'sd65536 - MAC_B_W'({1'b0, r_alpha});
                n_state = S_M3;
            end
            S_M3: begin
                s_ctl   = '{mul_en: 1'b0, acc_en: 1'b1, acc_clr: 1'b0, shift_sel: SH_FRAC};
                n_state = S_EST;
            end
            S_EST: n_state = S_INT;
            S_INT: n_state = S_PMUL;
            S_PMUL: begin
                s_ctl.mul_en = 1'b1;
                s_op_a  = MAC_A_W'(r_err);
                s_op_b  = MAC_B_W'(r_kp);
                n_state = S_IMUL;
            end
            S_IMUL: begin
                s_ctl   = '{mul_en: 1'b1, acc_en: 1'b1, acc_clr: 1'b1, shift_sel: SH_NONE};
                s_op_a  = MAC_A_W'(r_int);
                s_op_b  = MAC_B_W'(r_ki);
                n_state = S_DMUL;
            end
            S_DMUL: begin
                s_ctl   = '{mul_en: 1'b1, acc_en: 1'b1, acc_clr: 1'b0, shift_sel: SH_NONE};
                s_op_a  = MAC_A_W'(r_deriv);
                s_op_b  = MAC_B_W'(r_kd);
                n_state = S_DSUM;
            end
            S_DSUM: begin
                s_ctl   = '{mul_en: 1'b0, acc_en: 1'b1, acc_clr: 1'b0, shift_sel: SH_NONE};
                n_state = S_DRV;
            end
            S_DRV: n_state = S_OMUL;
            S_OMUL: begin
                s_ctl.mul_en = 1'b1;
                s_op_a  = s_dmag;
                s_op_b  = MAC_B_W'({1'b0, r_ogain});
                n_state = S_DUTY;
            end
            S_DUTY: n_state = S_OUT;
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kp     <= RST_KP;
            r_ki     <= RST_KI;
            r_kd     <= RST_KD;
            r_alpha  <= RST_ALPHA;
            r_ogain  <= RST_OGAIN;
            r_period <= RST_PERIOD;
            r_gbias  <= RST_GBIAS;
            r_abias  <= RST_ABIAS;
            r_est    <= '0;
            r_int    <= '0;
            r_last   <= '0;
            r_duty   <= RST_DUTY;
            r_fwd    <= 1'b0;
            r_angle  <= '0;
            r_drive  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KP:     r_kp     <= i_cfg_data;
                    CFG_KI:     r_ki     <= i_cfg_data;
                    CFG_KD:     r_kd     <= i_cfg_data;
                    CFG_ALPHA:  r_alpha  <= i_cfg_data;
                    CFG_OGAIN:  r_ogain  <= i_cfg_data;
                    CFG_PERIOD: r_period <= i_cfg_data;
                    CFG_GBIAS:  r_gbias  <= i_cfg_data;
                    CFG_ABIAS:  r_abias  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_EST) begin
                r_est <= EST_W'(s_est_sat);
            end
            if (r_state == S_INT) begin
                r_angle <= s_angle;
                r_int   <= s_isat;
            end
            if (r_state == S_DRV) begin
                r_drive <= s_dsat;
                r_fwd   <= !s_dsat[31] && (s_dsat != '0);
                r_last  <= r_err;
            end
            if (r_state == S_DUTY) begin
                r_duty <= s_duty;
            end
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_gd <= 17'(i_in.data.gyro_x) - 17'(r_gbias);
            r_ad <= 17'(i_in.data.accel_x) - 17'(r_abias);
        end
        if (r_state == S_GFIN) begin
            r_a     <= s_a;
            r_accel <= s_accel;
        end
        if (r_state == S_INT) begin
            r_err <= s_err;
        end
        if (r_state == S_PMUL) begin
            r_deriv <= 18'(r_err) - 18'(r_last);
        end
    end

    tbp_mac #(
        .ACC_W (ACC_W),
        .FRAC  (F)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctl  (s_ctl),
        .i_op_a (s_op_a),
        .i_op_b (s_op_b),
        .o_prod (s_prod),
        .o_acc  (s_acc)
    );

    // Tick transactions drive the PWM stage directly
    always_comb begin
        s_pwm.tick     = s_accept && i_in.data.req_type;
        s_pwm.fwd_flag = r_fwd;
        s_pwm.duty     = r_duty;
        s_pwm.period   = r_period;
    end

    tbp_pwm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_pwm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (s_pwm),
        .o_pin_fwd (s_pin_fwd),
        .o_pin_rev (s_pin_rev)
    );

    // Handshake and result payload
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    always_comb begin
        o_out.data.pin_forward = s_pin_fwd;
        o_out.data.pin_reverse = s_pin_rev;
        o_out.data.tilt_angle  = r_angle;
        o_out.data.duty_count  = r_duty;
        o_out.data.dir_forward = r_fwd;
        o_out.data.drive_value = r_drive;
    end

    // Forward direction only with a positive drive
    a_fwd_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> (!r_drive[31] && r_drive != '0))
        else $error("direction flag set without a positive drive");

    // Integral moves only in its own step
    a_int_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INT && i_rst_n) |=> $stable(r_int))
        else $error("integral changed outside its update step");

    // A result appears only after a tick accept or a completed duty step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == S_DUTY || $past(r_state) == S_IDLE))
        else $error("result offered from an unexpected step");

    // Duty fresh from a sample never exceeds the period
    a_duty_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && $past(r_state) == S_DUTY) |-> (r_duty <= r_period))
        else $error("duty exceeds the PWM period");

endmodule
